// ===== design/coc_pkg.sv =====
// Shared constants and the run descriptor type for the console output cooker.
`timescale 1ns / 1ps
package coc_pkg;

    localparam int TAB_WIDTH   = 4;
    localparam int MAX_RESULTS = 12;
    localparam int ERASE_CAP   = MAX_RESULTS / 3;
    localparam int COL_W       = 16;
    localparam int COL_MAX     = 65535;
    localparam int SAT_MOD     = COL_MAX % TAB_WIDTH;
    localparam int MOD_W       = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int LEN_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] PIC_B0   = 8'he2;
    localparam logic [7:0] PIC_B1   = 8'h90;
    localparam logic [7:0] PIC_BASE = 8'h80;

    localparam logic [2:0] K_BYTE   = 3'd0;
    localparam logic [2:0] K_CRLF   = 3'd1;
    localparam logic [2:0] K_PIC    = 3'd2;
    localparam logic [2:0] K_SPACES = 3'd3;
    localparam logic [2:0] K_ERASE  = 3'd4;

    localparam logic REG_COOKED = 1'b0;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       value;
        logic [LEN_W-1:0] len;
    } t_run;

endpackage

// ===== design/console_output_cooker_unit.sv =====
// Top level of the console output cooker: config register, front end, queue, expander.
`timescale 1ns / 1ps
// Usage:
//   Input stream (s side): one console byte per request in tdata, tuser set when
//   the next byte of the write is TAB, tlast on the final byte of a write.
//   Output stream (m side): terminal bytes in tdata, tlast on the final byte
//   produced for one input byte. A byte that yields nothing (erase at column 0)
//   produces no output request.
//   Config port: register cooked_mode at byte address 0 (bit 0), reset 1.
//   Path: an input byte passes the queue, the run register and the output register.
//   Throughput: a queued input byte expands to 1 to 12 bytes; the expander
//   emits one byte per cycle while the receiver is ready. The front end takes
//   one byte per cycle while the four-entry descriptor queue has room, so
//   short bursts are absorbed while a long run (tab, erase, picture) drains.
//   Reset: synchronous, clears the column, the queue and the output register
//   and sets cooked mode.
//   Stall: when the receiver drops tready the output byte holds; the expander
//   and then the queue fill, and s-side tready drops once the queue is full.
module console_output_cooker_unit import coc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] next_is_tab
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast
);

    logic r_cooked;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_run f_run;
    t_run q_run;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_COOKED) ? {31'b0, r_cooked} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooked <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr[2] == REG_COOKED) begin
            r_cooked <= i_pwdata[0];
        end
    end

    coc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cooked   (r_cooked),
        .i_valid    (i_s_tvalid),
        .i_byte     (i_s_tdata),
        .i_next_tab (i_s_tuser),
        .i_last     (i_s_tlast),
        .i_q_full   (q_full),
        .o_ready    (o_s_tready),
        .o_push     (q_push),
        .o_run      (f_run)
    );

    coc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_run),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_run)
    );

    coc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_run),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

endmodule

// ===== design/coc_front.sv =====
// Front end: accepts input bytes, classifies them and tracks the display column.
`timescale 1ns / 1ps
module coc_front import coc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cooked,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_next_tab,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_run       o_run
);

    logic [COL_W-1:0] r_col, n_col;
    logic [MOD_W-1:0] r_mod, n_mod;
    logic             enq;
    logic             accept;
    logic [LEN_W-1:0] base_l, want_l, cnt_l, tab_cnt;
    logic [COL_W:0]   tab_sum;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && enq;

    always_comb begin
        // distance back to the previous tab stop, a full stop when on one
        base_l  = (r_mod == '0) ? LEN_W'(TAB_WIDTH) : LEN_W'(r_mod);
        want_l  = i_next_tab ? base_l : LEN_W'(1);
        cnt_l   = (want_l > LEN_W'(ERASE_CAP)) ? LEN_W'(ERASE_CAP) : want_l;
        tab_cnt = LEN_W'(TAB_WIDTH) - LEN_W'(r_mod);
        tab_sum = {1'b0, r_col} + (COL_W + 1)'(tab_cnt);
    end

    always_comb begin
        enq         = 1'b1;
        o_run.kind  = K_BYTE;
        o_run.value = i_byte;
        o_run.len   = LEN_W'(1);
        n_col       = r_col;
        n_mod       = r_mod;
        if (i_cooked) begin
            if (i_byte == CH_BS || i_byte == CH_DEL) begin
                if (r_col == '0) begin
                    enq = 1'b0;
                end else begin
                    o_run.kind = K_ERASE;
                    o_run.len  = (cnt_l << 1) + cnt_l;
                    n_col      = r_col - COL_W'(cnt_l);
                    n_mod      = MOD_W'(base_l - cnt_l);
                end
            end else if (i_byte == CH_LF) begin
                o_run.kind = K_CRLF;
                o_run.len  = LEN_W'(2);
                n_col      = '0;
                n_mod      = '0;
            end else if (i_byte == CH_CR || i_byte == CH_FF) begin
                n_col = '0;
                n_mod = '0;
            end else if (i_byte == CH_TAB) begin
                o_run.kind = K_SPACES;
                o_run.len  = tab_cnt;
                if (tab_sum > (COL_W + 1)'(COL_MAX)) begin
                    n_col = COL_W'(COL_MAX);
                    n_mod = MOD_W'(SAT_MOD);
                end else begin
                    n_col = tab_sum[COL_W-1:0];
                    n_mod = '0;
                end
            end else if (i_byte == CH_BEL) begin
                n_col = r_col;
            end else begin
                if (i_byte < CH_SPACE) begin
                    o_run.kind = K_PIC;
                    o_run.len  = LEN_W'(3);
                end
                // hold the column once saturated
                if (r_col != COL_W'(COL_MAX)) begin
                    n_col = r_col + COL_W'(1);
                    n_mod = (LEN_W'(r_mod) == LEN_W'(TAB_WIDTH - 1)) ? '0 : r_mod + MOD_W'(1);
                end
            end
        end
        if (i_last) begin
            n_col = '0;
            n_mod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_mod <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_mod <= n_mod;
        end
    end

endmodule

// ===== design/coc_queue.sv =====
// Short descriptor queue between the front end and the byte expander.
`timescale 1ns / 1ps
module coc_queue import coc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_run o_data
);

    t_run                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;
    logic                do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== design/coc_back.sv =====
// Back end: expands run descriptors into terminal bytes, one per cycle while the receiver is ready.
`timescale 1ns / 1ps
module coc_back import coc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_run       i_q_data,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    t_run             r_run;
    logic             r_busy;
    logic [LEN_W-1:0] r_idx;
    logic [1:0]       r_phase;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             out_free;
    logic             emit;
    logic             run_end;
    logic [7:0]       cur_byte;

    assign out_free = !r_ovalid || i_ready;
    assign emit     = r_busy && out_free;
    assign run_end  = (r_idx == r_run.len - LEN_W'(1));
    assign o_q_pop  = (!r_busy || (emit && run_end)) && i_q_valid;

    always_comb begin
        case (r_run.kind)
            K_BYTE:   cur_byte = r_run.value;
            K_CRLF:   cur_byte = (r_idx == '0) ? CH_CR : CH_LF;
            K_PIC: begin
                if (r_idx == '0) begin
                    cur_byte = PIC_B0;
                end else if (r_idx == LEN_W'(1)) begin
                    cur_byte = PIC_B1;
                end else begin
                    cur_byte = PIC_BASE + r_run.value;
                end
            end
            K_SPACES: cur_byte = CH_SPACE;
            K_ERASE:  cur_byte = (r_phase == 2'd1) ? CH_SPACE : CH_BS;
            default:  cur_byte = r_run.value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_run <= i_q_data;
        end
        if (emit) begin
            r_obyte <= cur_byte;
            r_olast <= run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            // load the next run right behind the last byte of this one
            if (o_q_pop) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_phase <= '0;
            end else if (emit) begin
                if (run_end) begin
                    r_busy <= 1'b0;
                end
                r_idx   <= r_idx + LEN_W'(1);
                r_phase <= (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

endmodule

// ===== design/coc_checker.sv =====
// Port-level checker for the console output cooker, bound to the top level.
`timescale 1ns / 1ps
module coc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] o_prdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast
);

    // hold a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output request changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_reset_mode: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_paddr[2] || o_prdata[0]))
        else $error("cooked mode not set by reset");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && !i_paddr[2]
        |=> (i_paddr[2] || o_prdata[0] == $past(i_pwdata[0])))
        else $error("mode register readback mismatch");

    a_rdata_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prdata[31:1] == 31'b0)
        else $error("unused read data bits set");

endmodule

bind console_output_cooker_unit coc_checker u_coc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_psel     (i_psel),
    .i_penable  (i_penable),
    .i_pwrite   (i_pwrite),
    .i_paddr    (i_paddr),
    .i_pwdata   (i_pwdata),
    .o_prdata   (o_prdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
